>>> hw/rtl/srpg_pkg.sv
// ----------------------------------------------------------------------------
// srpg_pkg
// Shared widths, command codes and the result word type of the stepper ramp
// pulse generator.
// ----------------------------------------------------------------------------
package srpg_pkg;

   localparam int FREQ_WIDTH  = 16;
   localparam int COUNT_WIDTH = 32;
   localparam int RAMP_WIDTH  = 16;

   typedef enum logic [1:0] {
      CMD_TICK      = 2'd0,
      CMD_START_CW  = 2'd1,
      CMD_START_CCW = 2'd2,
      CMD_STOP      = 2'd3
   } cmd_type;

   typedef struct packed {
      logic                   pulse_level;
      logic                   direction;
      logic                   running;
      logic [FREQ_WIDTH-1:0]  frequency;
      logic [COUNT_WIDTH-1:0] pulses_done;
      logic                   move_done;
   } rsp_type;

endpackage

>>> hw/rtl/stepper_ramp_pulse_generator.sv
// ----------------------------------------------------------------------------
// stepper_ramp_pulse_generator
// Step pulse generator for one stepper move with a trapezoidal speed ramp.
// ----------------------------------------------------------------------------
// Each request word is a command: tick, start clockwise, start counterclockwise
// or stop. A start loads the start frequency, ramp steps, ramp lengths and the
// pulse total (ignored if the frequency or the total is zero). Every tick of a
// running move toggles the step level, counts a pulse on each falling edge and
// then raises the frequency while the count is below accel_pulses, or lowers
// it while count plus decel_pulses exceeds the total, saturating to 1..65535.
// The tick that finds the count at the total ends the move and flags
// move_done. Every request word yields exactly one response word carrying the
// state after that command; frequency is meant to reprogram the tick timer.
// Rate: one word per clock cycle while req_stall is low. The whole update is
// one pass of logic from the move state registers into the response register,
// or into the skid entry while that register holds a stalled word. A two-entry
// output buffer (response register plus skid) lets a request be taken while a
// response still waits; req_stall rises only when both entries are occupied.
// ----------------------------------------------------------------------------
module stepper_ramp_pulse_generator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_command,
   input  logic [srpg_pkg::FREQ_WIDTH-1:0]   req_start_frequency,
   input  logic [srpg_pkg::RAMP_WIDTH-1:0]   req_accel_step,
   input  logic [srpg_pkg::RAMP_WIDTH-1:0]   req_accel_pulses,
   input  logic [srpg_pkg::RAMP_WIDTH-1:0]   req_decel_step,
   input  logic [srpg_pkg::RAMP_WIDTH-1:0]   req_decel_pulses,
   input  logic [srpg_pkg::COUNT_WIDTH-1:0]  req_total_pulses,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_pulse_level,
   output logic                              rsp_direction,
   output logic                              rsp_running,
   output logic [srpg_pkg::FREQ_WIDTH-1:0]   rsp_frequency,
   output logic [srpg_pkg::COUNT_WIDTH-1:0]  rsp_pulses_done,
   output logic                              rsp_move_done
);

   logic              buf_full;
   logic              req_take;
   srpg_pkg::rsp_type next_word;
   srpg_pkg::rsp_type out_word;

   // Take a word whenever the skid entry is free.
   assign req_stall = buf_full;
   assign req_take  = req_valid && !buf_full;

   // Advance the move state and form the response word in the same cycle.
   srpg_core u_core (
      .clock           (clock),
      .reset           (reset),
      .item_take       (req_take),
      .command         (srpg_pkg::cmd_type'(req_command)),
      .start_frequency (req_start_frequency),
      .accel_step      (req_accel_step),
      .accel_pulses    (req_accel_pulses),
      .decel_step      (req_decel_step),
      .decel_pulses    (req_decel_pulses),
      .total_pulses    (req_total_pulses),
      .result          (next_word)
   );

   // Hold responses until the consumer takes them.
   srpg_obuf u_obuf (
      .clock     (clock),
      .reset     (reset),
      .push      (req_take),
      .push_word (next_word),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_word  (out_word)
   );

   assign rsp_pulse_level = out_word.pulse_level;
   assign rsp_direction   = out_word.direction;
   assign rsp_running     = out_word.running;
   assign rsp_frequency   = out_word.frequency;
   assign rsp_pulses_done = out_word.pulses_done;
   assign rsp_move_done   = out_word.move_done;

endmodule

>>> hw/rtl/srpg_core.sv
// ----------------------------------------------------------------------------
// srpg_core
// Move state and its combinational update for one accepted word.
// ----------------------------------------------------------------------------
module srpg_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                item_take,
   input  srpg_pkg::cmd_type                   command,
   input  logic [srpg_pkg::FREQ_WIDTH-1:0]     start_frequency,
   input  logic [srpg_pkg::RAMP_WIDTH-1:0]     accel_step,
   input  logic [srpg_pkg::RAMP_WIDTH-1:0]     accel_pulses,
   input  logic [srpg_pkg::RAMP_WIDTH-1:0]     decel_step,
   input  logic [srpg_pkg::RAMP_WIDTH-1:0]     decel_pulses,
   input  logic [srpg_pkg::COUNT_WIDTH-1:0]    total_pulses,
   output srpg_pkg::rsp_type                   result
);

   localparam int FW = srpg_pkg::FREQ_WIDTH;
   localparam int CW = srpg_pkg::COUNT_WIDTH;
   localparam int RW = srpg_pkg::RAMP_WIDTH;

   logic          run_ff,   run_in;
   logic          pulse_ff, pulse_in;
   logic          dir_ff,   dir_in;
   logic [FW-1:0] freq_ff,  freq_in;
   logic [RW-1:0] up_step_ff,   up_step_in;
   logic [RW-1:0] up_len_ff,    up_len_in;
   logic [RW-1:0] down_step_ff, down_step_in;
   logic [RW-1:0] down_len_ff,  down_len_in;
   logic [CW-1:0] total_ff, total_in;
   logic [CW-1:0] count_ff, count_in;
   logic          done;

   logic [CW-1:0]  count_after;
   logic           up_hit, down_hit;
   logic [FW+RW:0] up_sum;
   logic [CW:0]    down_sum;
   logic [FW-1:0]  freq_ramped;

   // Ramp decision on the count as it stands after this tick's toggle.
   always_comb begin
      count_after = pulse_ff ? count_ff + CW'(1) : count_ff;
      up_hit      = (up_step_ff != '0) && (up_len_ff != '0) &&
                    (count_after < CW'(up_len_ff));
      down_sum    = {1'b0, count_after} + (CW+1)'(down_len_ff);
      down_hit    = (down_step_ff != '0) && (down_len_ff != '0) &&
                    (down_sum > {1'b0, total_ff});
      up_sum      = (FW+RW+1)'(freq_ff) + (FW+RW+1)'(up_step_ff);
      if (up_hit) begin
         freq_ramped = (up_sum[FW+RW:FW] != '0) ? '1 : up_sum[FW-1:0];
      end else if (down_hit) begin
         freq_ramped = ((FW+RW)'(down_step_ff) >= (FW+RW)'(freq_ff)) ? FW'(1)
                       : freq_ff - FW'(down_step_ff);
      end else begin
         freq_ramped = freq_ff;
      end
   end

   always_comb begin
      run_in       = run_ff;
      pulse_in     = pulse_ff;
      dir_in       = dir_ff;
      freq_in      = freq_ff;
      up_step_in   = up_step_ff;
      up_len_in    = up_len_ff;
      down_step_in = down_step_ff;
      down_len_in  = down_len_ff;
      total_in     = total_ff;
      count_in     = count_ff;
      done         = 1'b0;
      unique case (command)
         srpg_pkg::CMD_TICK: begin
            if (run_ff) begin
               if (count_ff >= total_ff) begin
                  run_in   = 1'b0;
                  pulse_in = 1'b0;
                  done     = 1'b1;
               end else begin
                  pulse_in = ~pulse_ff;
                  count_in = count_after;
                  freq_in  = freq_ramped;
               end
            end
         end
         srpg_pkg::CMD_STOP: begin
            run_in       = 1'b0;
            pulse_in     = 1'b0;
            freq_in      = '0;
            up_step_in   = '0;
            up_len_in    = '0;
            down_step_in = '0;
            down_len_in  = '0;
            total_in     = '0;
         end
         srpg_pkg::CMD_START_CW, srpg_pkg::CMD_START_CCW: begin
            if (start_frequency != '0 && total_pulses != '0) begin
               dir_in       = (command == srpg_pkg::CMD_START_CCW);
               pulse_in     = 1'b0;
               freq_in      = start_frequency;
               up_step_in   = accel_step;
               up_len_in    = accel_pulses;
               down_step_in = decel_step;
               down_len_in  = decel_pulses;
               total_in     = total_pulses;
               count_in     = '0;
               run_in       = 1'b1;
            end
         end
         default: begin
         end
      endcase
      result.pulse_level = pulse_in;
      result.direction   = dir_in;
      result.running     = run_in;
      result.frequency   = freq_in;
      result.pulses_done = count_in;
      result.move_done   = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff       <= 1'b0;
         pulse_ff     <= 1'b0;
         dir_ff       <= 1'b0;
         freq_ff      <= '0;
         up_step_ff   <= '0;
         up_len_ff    <= '0;
         down_step_ff <= '0;
         down_len_ff  <= '0;
         total_ff     <= '0;
         count_ff     <= '0;
      end else if (item_take) begin
         run_ff       <= run_in;
         pulse_ff     <= pulse_in;
         dir_ff       <= dir_in;
         freq_ff      <= freq_in;
         up_step_ff   <= up_step_in;
         up_len_ff    <= up_len_in;
         down_step_ff <= down_step_in;
         down_len_ff  <= down_len_in;
         total_ff     <= total_in;
         count_ff     <= count_in;
      end
   end

endmodule

>>> hw/rtl/srpg_obuf.sv
// ----------------------------------------------------------------------------
// srpg_obuf
// Result register with a skid stage so the input side never waits on a
// single stalled result.
// ----------------------------------------------------------------------------
module srpg_obuf (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  srpg_pkg::rsp_type push_word,
   output logic              full,
   output logic              out_valid,
   input  logic              out_stall,
   output srpg_pkg::rsp_type out_word
);

   logic              main_valid_ff, main_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   srpg_pkg::rsp_type main_ff, main_in;
   srpg_pkg::rsp_type skid_ff, skid_in;
   logic              pop;

   always_comb begin
      pop           = main_valid_ff && !out_stall;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         // Input side is held off; drain skid into main on a pop.
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_in       = push_word;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_word;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_word  = main_ff;

endmodule

>>> hw/rtl/srpg_checker.sv
// ----------------------------------------------------------------------------
// srpg_checker
// Port-level checks of the stepper ramp pulse generator, bound to the top.
// ----------------------------------------------------------------------------
module srpg_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic                              rsp_pulse_level,
   input logic                              rsp_running,
   input logic [srpg_pkg::FREQ_WIDTH-1:0]   rsp_frequency,
   input logic [srpg_pkg::COUNT_WIDTH-1:0]  rsp_pulses_done,
   input logic                              rsp_move_done
);

   // The tick that ends a move leaves the block idle with the pulse low.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_move_done |-> !rsp_running && !rsp_pulse_level)
      else $error("move_done with running or pulse high");

   // The step output is never high outside a move.
   a_idle_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_running |-> !rsp_pulse_level)
      else $error("pulse high while idle");

   // A running move always has a usable timer frequency.
   a_freq_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_running |-> rsp_frequency != '0)
      else $error("zero frequency while running");

   // A stalled response word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_frequency) &&
                                 $stable(rsp_pulses_done))
      else $error("stalled response changed");

endmodule

bind stepper_ramp_pulse_generator srpg_checker u_srpg_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_pulse_level (rsp_pulse_level),
   .rsp_running     (rsp_running),
   .rsp_frequency   (rsp_frequency),
   .rsp_pulses_done (rsp_pulses_done),
   .rsp_move_done   (rsp_move_done)
);
